### rtl/isotp_rx_reassembler_core_assert.svh
// Assertion macros used by the reassembler core.
`ifndef ISOTP_RX_REASSEMBLER_CORE_ASSERT_SVH
`define ISOTP_RX_REASSEMBLER_CORE_ASSERT_SVH

// Implication checked every cycle outside reset.
`define ISOTP_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Condition that must never hold outside reset.
`define ISOTP_ASSERT_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

`endif

### rtl/isotp_pkg.sv
package isotp_pkg;

   // Field widths
   localparam int KIND_W   = 2;
   localparam int FRAME_W  = 64;
   localparam int IDX_W    = 12;
   localparam int EVENT_W  = 3;
   localparam int LEN_W    = 12;
   localparam int PAYLD_W  = 56;
   localparam int BYTE_W   = 8;
   localparam int CSR_IDX_W = 8;
   localparam int CSR_DAT_W = 8;

   // Reassembly buffer
   localparam int BUFFER_BYTES = 4096;
   localparam int ADDR_W       = $clog2(BUFFER_BYTES);

   // Command queue depth between front and back (power of two)
   localparam int Q_DEPTH = 2;

   // Protocol constants
   localparam logic [7:0]       FC_PCI          = 8'h30;
   localparam logic [LEN_W-1:0] SF_MAX_LEN      = 12'd7;
   localparam logic [LEN_W-1:0] FF_STORED_BYTES = 12'd6;
   localparam logic [2:0]       FF_NBYTES       = 3'd6;
   localparam logic [2:0]       CF_MAX_BYTES    = 3'd7;
   localparam logic [3:0]       SEQ_FIRST       = 4'd1;

   // Configuration register reset values
   localparam logic [7:0] FC_BS_RESET = 8'd8;
   localparam logic [7:0] FC_ST_RESET = 8'd15;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FC_BLOCK_SIZE = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FC_SEP_TIME   = 8'd1;

   typedef enum logic [KIND_W-1:0] {
      KIND_SINGLE = 2'd0,
      KIND_FIRST  = 2'd1,
      KIND_CONSEC = 2'd2,
      KIND_READ   = 2'd3
   } kind_type;

   typedef enum logic [EVENT_W-1:0] {
      EV_IGNORED   = 3'd0,
      EV_SINGLE    = 3'd1,
      EV_FIRST_FC  = 3'd2,
      EV_CF_OK     = 3'd3,
      EV_BLOCK_FC  = 3'd4,
      EV_COMPLETE  = 3'd5,
      EV_SEQ_ERROR = 3'd6,
      EV_READ      = 3'd7
   } ev_type;

   // One classified item, handed from front to back
   typedef struct packed {
      ev_type                  event_res;
      logic [LEN_W-1:0]        length;
      logic [6:0][BYTE_W-1:0]  data;       // data[6] is the first byte
      logic [FRAME_W-1:0]      fc_frame;
      logic [IDX_W-1:0]        base;       // first buffer index written
      logic [2:0]              nbytes;     // bytes to write, 0..7
      logic                    rd_en;      // buffer read in range
      logic [IDX_W-1:0]        read_index;
   } cmd_type;

endpackage

### rtl/isotp_ifs.sv
// Request channel: one frame or buffer read per item
interface isotp_req_if;
   logic                          valid;
   logic                          ready;
   logic [isotp_pkg::KIND_W-1:0]  kind;
   logic [isotp_pkg::FRAME_W-1:0] frame;
   logic [isotp_pkg::IDX_W-1:0]   read_index;

   modport source (output valid, kind, frame, read_index, input ready);
   modport sink   (input valid, kind, frame, read_index, output ready);
endinterface

// Response channel: one result per item
interface isotp_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [isotp_pkg::EVENT_W-1:0] event_res;
   logic [isotp_pkg::LEN_W-1:0]   length;
   logic [isotp_pkg::PAYLD_W-1:0] payload;
   logic [isotp_pkg::FRAME_W-1:0] fc_frame;
   logic [isotp_pkg::BYTE_W-1:0]  read_byte;

   modport source (output valid, event_res, length, payload, fc_frame, read_byte,
                   input ready);
   modport sink   (input valid, event_res, length, payload, fc_frame, read_byte,
                   output ready);
endinterface

// Register write channel
interface isotp_csr_if;
   logic                            valid;
   logic                            ready;
   logic [isotp_pkg::CSR_IDX_W-1:0] index;
   logic [isotp_pkg::CSR_DAT_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### rtl/isotp_front.sv
module isotp_front (
   input  logic               clock,
   input  logic               reset,
   isotp_req_if.sink          req_chan,
   isotp_csr_if.sink          csr_chan,
   output logic               push_valid,
   input  logic               push_ready,
   output isotp_pkg::cmd_type push_cmd
);
   import isotp_pkg::*;

   logic                 rx_busy_ff, rx_busy_in;
   logic [LEN_W-1:0]     total_length_ff, total_length_in;
   logic [LEN_W-1:0]     received_count_ff, received_count_in;
   logic [3:0]           expected_sequence_ff, expected_sequence_in;
   logic [7:0]           block_frames_ff, block_frames_in;
   logic [7:0]           fc_block_size_ff;
   logic [7:0]           fc_separation_time_ff;

   logic                 accept;
   logic [3:0]           nibble;
   logic [LEN_W-1:0]     remain;
   logic [2:0]           cf_bytes;
   logic [LEN_W-1:0]     count_next;
   logic [7:0]           frames_next;
   logic [FRAME_W-1:0]   fc_word;
   cmd_type              cmd;

   assign accept         = req_chan.valid && push_ready;
   assign req_chan.ready = push_ready;
   assign csr_chan.ready = 1'b1;
   assign push_valid     = req_chan.valid;
   assign push_cmd       = cmd;

   assign nibble  = req_chan.frame[59:56];
   assign fc_word = {FC_PCI, fc_block_size_ff, fc_separation_time_ff, 40'h0};

   // Remainder saturates at zero, at most seven bytes per consecutive frame
   assign remain      = (total_length_ff > received_count_ff) ?
                        (total_length_ff - received_count_ff) : '0;
   assign cf_bytes    = (remain > LEN_W'(CF_MAX_BYTES)) ? CF_MAX_BYTES : remain[2:0];
   assign count_next  = received_count_ff + LEN_W'(cf_bytes);
   assign frames_next = block_frames_ff + 8'd1;

   // Classify the item and work out the next control state
   always_comb begin
      rx_busy_in           = rx_busy_ff;
      total_length_in      = total_length_ff;
      received_count_in    = received_count_ff;
      expected_sequence_in = expected_sequence_ff;
      block_frames_in      = block_frames_ff;
      cmd                  = '0;
      cmd.event_res        = EV_IGNORED;
      cmd.read_index       = req_chan.read_index;

      unique case (kind_type'(req_chan.kind))
         KIND_SINGLE: begin
            if (!rx_busy_ff) begin
               cmd.event_res = EV_SINGLE;
               cmd.length    = (LEN_W'(nibble) > SF_MAX_LEN) ? SF_MAX_LEN : LEN_W'(nibble);
               cmd.data      = req_chan.frame[55:0];
            end
         end
         KIND_FIRST: begin
            if (!rx_busy_ff) begin
               total_length_in      = {nibble, req_chan.frame[55:48]};
               received_count_in    = FF_STORED_BYTES;
               expected_sequence_in = SEQ_FIRST;
               block_frames_in      = '0;
               rx_busy_in           = 1'b1;
               cmd.event_res        = EV_FIRST_FC;
               cmd.fc_frame         = fc_word;
               cmd.base             = '0;
               cmd.nbytes           = FF_NBYTES;
               cmd.data             = {req_chan.frame[47:0], 8'h00};
            end
         end
         KIND_CONSEC: begin
            if (rx_busy_ff) begin
               if (nibble == expected_sequence_ff) begin
                  cmd.base             = received_count_ff;
                  cmd.nbytes           = cf_bytes;
                  cmd.data             = req_chan.frame[55:0];
                  received_count_in    = count_next;
                  expected_sequence_in = expected_sequence_ff + 4'd1;
                  block_frames_in      = frames_next;
                  if (count_next >= total_length_ff) begin
                     cmd.event_res = EV_COMPLETE;
                     cmd.length    = total_length_ff;
                     rx_busy_in    = 1'b0;
                  end else if (fc_block_size_ff != 8'd0 && frames_next == fc_block_size_ff) begin
                     block_frames_in = '0;
                     cmd.event_res   = EV_BLOCK_FC;
                     cmd.fc_frame    = fc_word;
                  end else begin
                     cmd.event_res = EV_CF_OK;
                  end
               end else begin
                  rx_busy_in    = 1'b0;
                  cmd.event_res = EV_SEQ_ERROR;
               end
            end
         end
         KIND_READ: begin
            cmd.event_res = EV_READ;
            cmd.rd_en     = (req_chan.read_index < received_count_ff) &&
                            ({1'b0, req_chan.read_index} < (IDX_W+1)'(BUFFER_BYTES));
         end
      endcase
   end

   // Control state, updated on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         rx_busy_ff           <= 1'b0;
         total_length_ff      <= '0;
         received_count_ff    <= '0;
         expected_sequence_ff <= '0;
         block_frames_ff      <= '0;
      end else if (accept) begin
         rx_busy_ff           <= rx_busy_in;
         total_length_ff      <= total_length_in;
         received_count_ff    <= received_count_in;
         expected_sequence_ff <= expected_sequence_in;
         block_frames_ff      <= block_frames_in;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fc_block_size_ff      <= FC_BS_RESET;
         fc_separation_time_ff <= FC_ST_RESET;
      end else if (csr_chan.valid) begin
         if (csr_chan.index == CSR_FC_BLOCK_SIZE) begin
            fc_block_size_ff <= csr_chan.data;
         end
         if (csr_chan.index == CSR_FC_SEP_TIME) begin
            fc_separation_time_ff <= csr_chan.data;
         end
      end
   end

endmodule

### rtl/isotp_cmd_fifo.sv
module isotp_cmd_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  isotp_pkg::cmd_type push_cmd,
   output logic               pop_valid,
   input  logic               pop_ready,
   output isotp_pkg::cmd_type pop_cmd
);
   import isotp_pkg::*;

   localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int CNT_W = $clog2(Q_DEPTH + 1);

   cmd_type          slot_ff [Q_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(Q_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + CNT_W'(1);
            2'b01:   count_ff <= count_ff - CNT_W'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### rtl/isotp_back.sv
module isotp_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  isotp_pkg::cmd_type pop_cmd,
   isotp_rsp_if.source        rsp_chan
);
   import isotp_pkg::*;

   localparam int WADDR_W = IDX_W + 1;

   logic [BYTE_W-1:0]  mem [BUFFER_BYTES];

   cmd_type            cur_ff;
   logic               busy_ff, busy_in;
   logic [2:0]         wcnt_ff, wcnt_in;
   logic               primed_ff;
   logic [BYTE_W-1:0]  rd_data_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [EVENT_W-1:0] ev_ff;
   logic [LEN_W-1:0]   len_ff;
   logic [PAYLD_W-1:0] pay_ff;
   logic [FRAME_W-1:0] fc_ff;
   logic [BYTE_W-1:0]  rb_ff;

   logic               out_free, last_write, done_simple, finish, pop;
   logic               wr_en;
   logic [WADDR_W-1:0] wr_addr;

   assign out_free    = !rsp_valid_ff || rsp_chan.ready;
   assign last_write  = busy_ff && (cur_ff.nbytes != 3'd0) &&
                        (wcnt_ff == cur_ff.nbytes - 3'd1);
   assign done_simple = busy_ff && (cur_ff.nbytes == 3'd0) && (!cur_ff.rd_en || primed_ff);
   assign finish      = (last_write || done_simple) && out_free;
   assign pop         = pop_valid && (!busy_ff || finish);
   assign pop_ready   = pop;

   // One buffer byte per cycle; a write repeated while the output stalls is harmless
   assign wr_addr = {1'b0, cur_ff.base} + WADDR_W'(wcnt_ff);
   assign wr_en   = busy_ff && (wcnt_ff < cur_ff.nbytes) &&
                    (wr_addr < WADDR_W'(BUFFER_BYTES));

   always_comb begin
      busy_in = busy_ff;
      wcnt_in = wcnt_ff;
      if (pop) begin
         busy_in = 1'b1;
         wcnt_in = '0;
      end else begin
         if (finish) begin
            busy_in = 1'b0;
         end
         if (busy_ff && (wcnt_ff < cur_ff.nbytes) && !last_write) begin
            wcnt_in = wcnt_ff + 3'd1;
         end
      end
   end

   assign rsp_valid_in = finish ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         wcnt_ff      <= '0;
         primed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         wcnt_ff      <= wcnt_in;
         primed_ff    <= pop ? 1'b0 : busy_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Current command and result registers
   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= pop_cmd;
      end
      if (finish) begin
         ev_ff  <= cur_ff.event_res;
         len_ff <= cur_ff.length;
         pay_ff <= (cur_ff.event_res == EV_SINGLE) ? cur_ff.data : '0;
         fc_ff  <= cur_ff.fc_frame;
         rb_ff  <= cur_ff.rd_en ? rd_data_ff : '0;
      end
   end

   // Reassembly buffer: one write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr[ADDR_W-1:0]] <= cur_ff.data[3'd6 - wcnt_ff];
      end
      rd_data_ff <= mem[cur_ff.read_index[ADDR_W-1:0]];
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.event_res = ev_ff;
   assign rsp_chan.length    = len_ff;
   assign rsp_chan.payload   = pay_ff;
   assign rsp_chan.fc_frame  = fc_ff;
   assign rsp_chan.read_byte = rb_ff;

endmodule

### rtl/isotp_rx_reassembler_core.sv
// ISO-TP receive reassembler. Each request item is a CAN frame tagged single,
// first or consecutive, or a read of the reassembly buffer; each gives exactly
// one response item. The front end takes one item per clock while the queue
// has room, updates the reassembly state at once and queues a command (two
// entries); the back end writes frame bytes into the 4096-byte buffer one byte
// per clock over its single write port, the last byte held while the output
// stalls: six bytes for a first frame, 0 to 7 for a consecutive frame and none
// for other items; a buffer read uses registered read data. Flow-control
// settings come from the two registers and are sampled when the first or
// block-ending frame is taken. The buffer is not cleared at reset; reads only
// reach bytes below the received count, which are always written first.
module isotp_rx_reassembler_core (
   input  logic        clock,
   input  logic        reset,
   isotp_req_if.sink   req_chan,
   isotp_rsp_if.source rsp_chan,
   isotp_csr_if.sink   csr_chan
);
   import isotp_pkg::*;

   `include "isotp_rx_reassembler_core_assert.svh"

   logic    push_valid, push_ready;
   cmd_type push_cmd;
   logic    pop_valid, pop_ready;
   cmd_type pop_cmd;

   isotp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .csr_chan   (csr_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   isotp_cmd_fifo u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   isotp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_cmd   (pop_cmd),
      .rsp_chan  (rsp_chan)
   );

   // Result fields only carry data for the events that own them; single-frame length stays clamped
   `ISOTP_ASSERT_IMPLY(a_read_byte_only_on_read, rsp_chan.valid && rsp_chan.read_byte != '0, rsp_chan.event_res == EV_READ, "read byte set outside a read")
   `ISOTP_ASSERT_IMPLY(a_fc_only_on_fc_events, rsp_chan.valid && rsp_chan.fc_frame != '0, rsp_chan.event_res == EV_FIRST_FC || rsp_chan.event_res == EV_BLOCK_FC, "flow control on wrong event")
   `ISOTP_ASSERT_IMPLY(a_single_len_clamped, rsp_chan.valid && rsp_chan.event_res == EV_SINGLE, rsp_chan.length <= SF_MAX_LEN, "single frame length above seven")
   // The back end never takes a command the queue does not hold
   `ISOTP_ASSERT_NEVER(a_pop_empty_queue, pop_ready && !pop_valid, "pop from empty queue")

endmodule

### test/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import isotp_pkg::*;

   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 12;

   // One response item, field by field
   typedef struct packed {
      ev_type               ev;
      logic [LEN_W-1:0]     len;
      logic [PAYLD_W-1:0]   pay;
      logic [FRAME_W-1:0]   fc;
      logic [BYTE_W-1:0]    rb;
   } reasm_result_type;

   // Hand-written expectation for a directed item, if it has one
   typedef struct {
      bit               pinned;
      reasm_result_type want;
   } typed_expect_type;

   typedef struct {
      kind_type             kind;
      logic [FRAME_W-1:0]   frame;
      logic [IDX_W-1:0]     idx;
      bit                   pinned;
      reasm_result_type     want;
   } stim_row_type;

   logic clock;
   logic reset;

   isotp_req_if req_bus ();
   isotp_rsp_if rsp_bus ();
   isotp_csr_if csr_bus ();

   isotp_rx_reassembler_core u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // Reassembly state as seen by the checker
   logic               fr_busy;
   int                 fr_total;
   int                 fr_recv;
   logic [3:0]         fr_seq;
   logic [7:0]         fr_blk;
   logic [BYTE_W-1:0]  fr_buf [BUFFER_BYTES];
   logic [7:0]         cfg_bs;
   logic [7:0]         cfg_st;

   reasm_result_type   pending_results [$];
   typed_expect_type   typed_q [$];
   stim_row_type       stim_rows [$];
   int                 mismatches = 0;

   // Traffic shaping
   int                 snd_idle_pct = 0;
   int                 rcv_stall_pct = 0;
   int                 hold_req = 0;
   int                 hold_seen = 0;
   int                 hold_left = 0;

   // Sender's view of the message it is building
   logic               g_busy = 1'b0;
   int                 g_total = 0;
   int                 g_recv = 0;
   logic [3:0]         g_seq = 4'd0;
   int                 g_next_total = -1;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("TEST FAILED");
      $finish;
   end

   task automatic report(string field, logic [63:0] got, logic [63:0] want);
      mismatches++;
      $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, field, got, want);
   endtask

   // Next result of the reassembler for one accepted item; updates state
   function automatic reasm_result_type reassemble(kind_type k, logic [FRAME_W-1:0] f,
                                                   logic [IDX_W-1:0] ri);
      reasm_result_type r;
      int n, rem, i, pos;
      r = '0;
      r.ev = EV_IGNORED;
      case (k)
         KIND_SINGLE: begin
            if (!fr_busy) begin
               n = int'(f[59:56]);
               if (n > 7) n = 7;
               r.ev  = EV_SINGLE;
               r.len = LEN_W'(n);
               r.pay = f[55:0];
            end
         end
         KIND_FIRST: begin
            if (!fr_busy) begin
               fr_total = int'(f[59:48]);
               // bytes 2..7 always land in the buffer, even for short totals
               for (i = 0; i < 6; i++) fr_buf[i] = f[47-8*i -: 8];
               fr_recv = 6;
               fr_seq  = 4'd1;
               fr_blk  = 8'd0;
               fr_busy = 1'b1;
               r.ev = EV_FIRST_FC;
               r.fc = {FC_PCI, cfg_bs, cfg_st, 40'h0};
            end
         end
         KIND_CONSEC: begin
            if (fr_busy) begin
               if (f[59:56] == fr_seq) begin
                  rem = (fr_total > fr_recv) ? fr_total - fr_recv : 0;
                  n = (rem > 7) ? 7 : rem;
                  for (i = 0; i < n; i++) begin
                     pos = fr_recv + i;
                     if (pos < BUFFER_BYTES) fr_buf[pos] = f[55-8*i -: 8];
                  end
                  fr_recv = (fr_recv + n) & 'hFFF;
                  fr_seq  = fr_seq + 4'd1;
                  fr_blk  = fr_blk + 8'd1;
                  if (fr_recv >= fr_total) begin
                     r.ev  = EV_COMPLETE;
                     r.len = LEN_W'(fr_total);
                     fr_busy = 1'b0;
                  end else if (cfg_bs != 8'd0 && fr_blk == cfg_bs) begin
                     fr_blk = 8'd0;
                     r.ev = EV_BLOCK_FC;
                     r.fc = {FC_PCI, cfg_bs, cfg_st, 40'h0};
                  end else begin
                     r.ev = EV_CF_OK;
                  end
               end else begin
                  // out of sequence: abort, keep received count
                  fr_busy = 1'b0;
                  r.ev = EV_SEQ_ERROR;
               end
            end
         end
         default: begin
            r.ev = EV_READ;
            if (int'(ri) < fr_recv && int'(ri) < BUFFER_BYTES) r.rb = fr_buf[ri];
         end
      endcase
      return r;
   endfunction

   // Observe all three channels at each edge: registers, items in, items out
   always @(posedge clock) begin : observe
      reasm_result_type pred, exp_r;
      typed_expect_type te;
      if (reset) begin
         fr_busy  = 1'b0;
         fr_total = 0;
         fr_recv  = 0;
         fr_seq   = 4'd0;
         fr_blk   = 8'd0;
         cfg_bs   = FC_BS_RESET;
         cfg_st   = FC_ST_RESET;
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               CSR_FC_BLOCK_SIZE: cfg_bs = csr_bus.data;
               CSR_FC_SEP_TIME:   cfg_st = csr_bus.data;
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready) begin
            pred = reassemble(kind_type'(req_bus.kind), req_bus.frame, req_bus.read_index);
            te.pinned = 1'b0;
            if (typed_q.size() != 0) te = typed_q.pop_front();
            pending_results.push_back(te.pinned ? te.want : pred);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_results.size() == 0) begin
               report("item with nothing pending", rsp_bus.event_res, 0);
            end else begin
               exp_r = pending_results.pop_front();
               if (rsp_bus.event_res !== exp_r.ev)  report("event_res", rsp_bus.event_res, exp_r.ev);
               if (rsp_bus.length    !== exp_r.len) report("length", rsp_bus.length, exp_r.len);
               if (rsp_bus.payload   !== exp_r.pay) report("payload", rsp_bus.payload, exp_r.pay);
               if (rsp_bus.fc_frame  !== exp_r.fc)  report("fc_frame", rsp_bus.fc_frame, exp_r.fc);
               if (rsp_bus.read_byte !== exp_r.rb)  report("read_byte", rsp_bus.read_byte, exp_r.rb);
            end
         end
      end
   end

   // Response side: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_seen != hold_req) begin
         hold_seen = hold_req;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
      end
   end

   function automatic void add_row(kind_type k, logic [FRAME_W-1:0] f, logic [IDX_W-1:0] ri,
                                   bit pinned, ev_type ev, logic [LEN_W-1:0] len,
                                   logic [PAYLD_W-1:0] pay, logic [FRAME_W-1:0] fc,
                                   logic [BYTE_W-1:0] rb);
      stim_row_type row;
      row.kind       = k;
      row.frame      = f;
      row.idx        = ri;
      row.pinned     = pinned;
      row.want.ev    = ev;
      row.want.len   = len;
      row.want.pay   = pay;
      row.want.fc    = fc;
      row.want.rb    = rb;
      stim_rows.push_back(row);
   endfunction

   // Present one item and hold it until it is taken
   task automatic offer(kind_type k, logic [FRAME_W-1:0] f, logic [IDX_W-1:0] ri, bit pinned,
                        reasm_result_type want);
      typed_expect_type te;
      te.pinned = pinned;
      te.want   = want;
      while ($urandom_range(0, 99) < snd_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      typed_q.push_back(te);
      req_bus.valid      <= 1'b1;
      req_bus.kind       <= k;
      req_bus.frame      <= f;
      req_bus.read_index <= ri;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
   endtask

   // Stop sending and wait until every pending item has come back
   task automatic settle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0 || typed_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] value);
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      csr_bus.valid <= 1'b1;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly well-formed messages with random content; some noise and
   // broken sequences unless clean is set
   task automatic gen_item(bit clean);
      int pick, roll, total, rem, span;
      kind_type k;
      logic [FRAME_W-1:0] f;
      logic [IDX_W-1:0] ri;
      f = {$urandom, $urandom};
      span = (g_recv + 2 > BUFFER_BYTES - 1) ? BUFFER_BYTES - 1 : g_recv + 2;
      ri = ($urandom_range(0, 3) != 0) ? IDX_W'($urandom_range(0, span)) : IDX_W'($urandom);
      pick = $urandom_range(0, 99);
      k = KIND_READ;
      if (!g_busy) begin
         if (clean || pick < 55) begin
            if (g_next_total >= 0) begin
               total = g_next_total;
            end else begin
               roll = $urandom_range(0, 99);
               if (roll < 90)      total = $urandom_range(0, 60);
               else if (roll < 99) total = $urandom_range(61, 300);
               else                total = $urandom_range(301, 1000);
            end
            g_next_total = -1;
            k = KIND_FIRST;
            f[59:48] = total[11:0];
            g_total = total;
            g_recv  = 6;
            g_seq   = SEQ_FIRST;
            g_busy  = 1'b1;
         end else if (pick < 72) begin
            k = KIND_SINGLE;
         end else if (pick >= 94) begin
            k = KIND_CONSEC;   // stray, ignored while idle
         end
      end else if (pick < (clean ? 85 : 74)) begin
         k = KIND_CONSEC;
         f[59:56] = g_seq;
         g_seq = g_seq + 4'd1;
         rem = (g_total > g_recv) ? g_total - g_recv : 0;
         g_recv += (rem > 7) ? 7 : rem;
         if (g_recv >= g_total) g_busy = 1'b0;
      end else if (!clean && pick < 80) begin
         k = KIND_CONSEC;
         f[59:56] = g_seq + 4'($urandom_range(1, 15));
         g_busy = 1'b0;
      end else if (!clean && pick < 86) begin
         k = ($urandom_range(0, 1) != 0) ? KIND_SINGLE : KIND_FIRST;
      end
      offer(k, f, ri, 1'b0, '0);
   endtask

   task automatic run_random(int n, int snd, int rcv);
      snd_idle_pct  = snd;
      rcv_stall_pct = rcv;
      repeat (n) gen_item(1'b0);
   endtask

   initial begin
      int i;
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.kind       <= KIND_SINGLE;
      req_bus.frame      <= '0;
      req_bus.read_index <= '0;
      csr_bus.valid      <= 1'b0;
      csr_bus.index      <= '0;
      csr_bus.data       <= '0;

      // Directed items under reset register values
      add_row(KIND_READ,   64'h0, 12'd0,    1, EV_READ, 12'd0, 56'h0, 64'h0, 8'h0);
      add_row(KIND_READ,   '1,    12'hFFF,  1, EV_READ, 12'd0, 56'h0, 64'h0, 8'h0);
      add_row(KIND_CONSEC, 64'h2111_2233_4455_6677, 12'd0, 1, EV_IGNORED, 12'd0, 56'h0,
              64'h0, 8'h0);
      add_row(KIND_SINGLE, '1, 12'd0, 1, EV_SINGLE, 12'd7, 56'hFF_FFFF_FFFF_FFFF, 64'h0, 8'h0);
      add_row(KIND_SINGLE, 64'h0, 12'hFFF, 1, EV_SINGLE, 12'd0, 56'h0, 64'h0, 8'h0);
      add_row(KIND_SINGLE, 64'h0711_2233_4455_6677, 12'd0, 1, EV_SINGLE, 12'd7,
              56'h11_2233_4455_6677, 64'h0, 8'h0);
      // length nibble above 7 is clamped
      add_row(KIND_SINGLE, 64'h08A5_0000_0000_005A, 12'd0, 1, EV_SINGLE, 12'd7,
              56'hA5_0000_0000_005A, 64'h0, 8'h0);
      // first frame with total below six
      add_row(KIND_FIRST,  64'h1003_A1A2_A3A4_A5A6, 12'd0, 1, EV_FIRST_FC, 12'd0, 56'h0,
              64'h3008_0F00_0000_0000, 8'h0);
      add_row(KIND_SINGLE, 64'h0312_3456_789A_BCDE, 12'd0, 1, EV_IGNORED, 12'd0, 56'h0,
              64'h0, 8'h0);
      add_row(KIND_FIRST,  64'h1050_FFFF_FFFF_FFFF, 12'd0, 1, EV_IGNORED, 12'd0, 56'h0,
              64'h0, 8'h0);
      add_row(KIND_READ,   64'h0, 12'd5, 0, EV_IGNORED, '0, '0, '0, '0);
      add_row(KIND_READ,   64'h0, 12'd3, 0, EV_IGNORED, '0, '0, '0, '0);
      add_row(KIND_CONSEC, 64'h21B1_B2B3_B4B5_B6B7, 12'd0, 0, EV_IGNORED, '0, '0, '0, '0);
      add_row(KIND_READ,   64'h0, 12'd6, 0, EV_IGNORED, '0, '0, '0, '0);
      // zero total completes on the first consecutive frame
      add_row(KIND_FIRST,  64'h1000_0102_0304_0506, 12'd0, 1, EV_FIRST_FC, 12'd0, 56'h0,
              64'h3008_0F00_0000_0000, 8'h0);
      add_row(KIND_CONSEC, 64'h2100_0000_0000_0000, 12'd0, 0, EV_IGNORED, '0, '0, '0, '0);
      add_row(KIND_FIRST,  64'h1014_0102_0304_0506, 12'd0, 1, EV_FIRST_FC, 12'd0, 56'h0,
              64'h3008_0F00_0000_0000, 8'h0);
      add_row(KIND_CONSEC, 64'h2107_0809_0A0B_0C0D, 12'd0, 0, EV_IGNORED, '0, '0, '0, '0);
      add_row(KIND_CONSEC, 64'h23EE_EEEE_EEEE_EEEE, 12'd0, 1, EV_SEQ_ERROR, 12'd0, 56'h0,
              64'h0, 8'h0);
      add_row(KIND_READ,   64'h0, 12'd12, 0, EV_IGNORED, '0, '0, '0, '0);
      add_row(KIND_CONSEC, 64'h2200_1122_3344_5566, 12'd0, 1, EV_IGNORED, 12'd0, 56'h0,
              64'h0, 8'h0);
      add_row(KIND_FIRST,  64'h1FFF_0011_2233_4455, 12'd0, 1, EV_FIRST_FC, 12'd0, 56'h0,
              64'h3008_0F00_0000_0000, 8'h0);
      add_row(KIND_CONSEC, 64'h20C0_FFEE_DDCC_BBAA, 12'd0, 1, EV_SEQ_ERROR, 12'd0, 56'h0,
              64'h0, 8'h0);
      add_row(KIND_READ,   64'h0, 12'hFFF, 0, EV_IGNORED, '0, '0, '0, '0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (stim_rows[j])
         offer(stim_rows[j].kind, stim_rows[j].frame, stim_rows[j].idx, stim_rows[j].pinned,
               stim_rows[j].want);
      settle();

      // One full-size message; block size changed twice while it is open,
      // the first time below the running frame count so the counter wraps
      write_reg(CSR_FC_BLOCK_SIZE, 8'd0);
      write_reg(CSR_FC_SEP_TIME, 8'd0);
      g_next_total = BUFFER_BYTES - 1;
      gen_item(1'b1);
      i = 0;
      while (g_busy) begin
         gen_item(1'b1);
         i++;
         if (i == 150) begin
            settle();
            write_reg(CSR_FC_BLOCK_SIZE, 8'd5);
         end
         if (i == 450) begin
            settle();
            write_reg(CSR_FC_BLOCK_SIZE, 8'd255);
            write_reg(CSR_FC_SEP_TIME, 8'd255);
         end
      end
      settle();

      write_reg(CSR_FC_BLOCK_SIZE, 8'd1);
      write_reg(CSR_FC_SEP_TIME, 8'h5A);
      run_random(130, 64, 0);
      settle();

      write_reg(CSR_FC_BLOCK_SIZE, 8'd2);
      write_reg(CSR_FC_SEP_TIME, 8'hA5);
      run_random(130, 0, 64);
      settle();

      write_reg(CSR_FC_BLOCK_SIZE, 8'd8);
      write_reg(CSR_FC_SEP_TIME, 8'hC3);
      run_random(130, 36, 36);
      settle();

      // Back-pressure: response side holds off while items keep coming,
      // then the sender waits for everything before going on
      write_reg(CSR_FC_BLOCK_SIZE, 8'd3);
      write_reg(CSR_FC_SEP_TIME, 8'h3C);
      hold_req++;
      run_random(40, 0, 0);
      settle();
      run_random(90, 0, 0);
      settle();

      if (mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
